// ----- rtl/core/ada_pkg.sv -----
// ============================================================================
// ada_pkg: shared types and constants for the Adagrad element update
// Item structs, register indexes and fixed-point limits.
// ============================================================================
package ada_pkg;

  localparam int unsigned ACCUM_DEPTH_DEF = 4096;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned LR_W    = 16;
  localparam int unsigned EPS_W   = 24;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 32;

  localparam logic [LR_W-1:0]  LR_RESET  = LR_W'(655);
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  typedef enum logic [CFG_A_W-1:0] {
    REG_STEP_SIZE = 2'd0,
    REG_EPSILON   = 2'd1
  } reg_index_t;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                    cmd;
    logic [IDX_W-1:0]        elem_index;
    logic signed [VAL_W-1:0] param_value;
    logic signed [VAL_W-1:0] grad_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_param;
    logic [ACC_W-1:0]        new_accum;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic [CFG_A_W-1:0] index;
    logic [CFG_D_W-1:0] wdata;
  } cfg_item_t;

endpackage

// ----- rtl/core/ada_in_if.sv -----
// ============================================================================
// ada_in_if: input item channel
// Valid/ready channel carrying one weight element item.
// ============================================================================
interface ada_in_if import ada_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/ada_out_if.sv -----
// ============================================================================
// ada_out_if: result item channel
// Valid/ready channel carrying one updated element item.
// ============================================================================
interface ada_out_if import ada_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/ada_cfg_if.sv -----
// ============================================================================
// ada_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ============================================================================
interface ada_cfg_if import ada_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/adagrad_element_update.sv -----
// ============================================================================
// adagrad_element_update: Adagrad per-element weight update engine
// Accumulates squared gradients per element and applies the scaled step.
// ============================================================================
//
//  channel  | dir | payload                                   | accepted when
//  ---------+-----+-------------------------------------------+---------------
//  in_ch    | in  | cmd, elem_index, param_value, grad_value  | valid & ready
//  out_ch   | out | new_param, new_accum, saturated           | valid & ready
//  cfg_ch   | in  | index (0 lr, 1 epsilon), wdata            | valid & ready
//
//  An update item runs a store read, the bit-serial square (the lr * |g|
//  product runs in its first half), accumulate and write back, the root
//  at two bits a cycle, the restoring divide at one quotient bit a cycle,
//  then the final add and clip, and the handoff.
//  Clear and out-of-range items go to the pass step. One item is in work
//  at a time. After reset a clearing pass zeroes the store with in_ch.ready
//  low; config writes are taken throughout (cfg_ch.ready is 1).
//  A finished result sits in the output register while the next item is
//  taken; the engine holds in its final step only if that register is full.
//
module adagrad_element_update import ada_pkg::*; #(
  parameter int unsigned ACCUM_DEPTH = ACCUM_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ada_in_if.sink     in_ch,
  ada_out_if.source  out_ch,
  ada_cfg_if.sink    cfg_ch
);

  localparam int unsigned AW = (ACCUM_DEPTH > 1) ? $clog2(ACCUM_DEPTH) : 1;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_ACC   = 9'b000010000,
    ST_SQRT  = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_PASS  = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [LR_W-1:0]  step_size;
  logic [EPS_W-1:0] epsilon;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= LR_RESET;
      epsilon   <= EPS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        REG_STEP_SIZE: step_size <= cfg_ch.data.wdata[LR_W-1:0];
        REG_EPSILON:   epsilon   <= cfg_ch.data.wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Accumulator store.
  logic [ACC_W-1:0] mem [ACCUM_DEPTH];
  logic [ACC_W-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [ACC_W-1:0] wr_data;
  logic [AW-1:0]    clr_addr;

  // Item registers.
  logic [AW-1:0]           addr;
  logic signed [VAL_W-1:0] param;
  logic                    grad_neg;
  logic [VAL_W-1:0]        mag;
  logic [63:0]             sq_p;     // square, shifts in the low half
  logic [ACC_W-1:0]        lp;       // lr * mag, then dividend / quotient
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        sx;       // radicand shift register
  logic [26:0]             srem;
  logic [EPS_W-1:0]        root;
  logic [28:0]             dv;
  logic [28:0]             drem;
  logic                    sat;
  logic [5:0]              cnt;

  // Output register.
  logic      out_full;
  out_item_t out_q;

  logic in_acc, out_acc, idx_ok;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;
  assign out_ch.valid = out_full;
  assign out_ch.data  = out_q;
  assign idx_ok = (32'(in_ch.data.elem_index) < 32'(ACCUM_DEPTH));

  // Datapath slices.
  logic [32:0] sq_sum, lp_sum;
  logic [55:0] sq_shift;
  logic [ACC_W-1:0] sq_clip;
  logic [ACC_W:0]   acc_sum;
  logic [26:0] srem2, strial;
  logic [24:0] denom;
  logic [29:0] dtry;
  logic        dge;
  logic [49:0] res_wide;
  logic        res_ovf;
  logic signed [VAL_W-1:0] res_clip;
  logic [VAL_W-1:0] in_mag;

  always_comb begin
    in_mag   = in_ch.data.grad_value[VAL_W-1] ? (~in_ch.data.grad_value + 1'b1)
                                              : in_ch.data.grad_value;
    sq_sum   = {1'b0, sq_p[63:32]} + (sq_p[0] ? {1'b0, mag} : 33'd0);
    lp_sum   = {1'b0, lp[47:16]} + (lp[0] ? {1'b0, mag} : 33'd0);
    sq_shift = sq_p[63:8];
    sq_clip  = (sq_shift[55:48] != 8'd0) ? {ACC_W{1'b1}} : sq_shift[47:0];
    acc_sum  = {1'b0, rd_data} + {1'b0, sq_clip};
    srem2    = {srem[24:0], sx[47:46]};
    strial   = {1'b0, root, 2'b01};
    denom    = {1'b0, root} + {1'b0, epsilon};
    if (denom == 25'd0) denom = 25'd1;
    dtry     = {drem, lp[47]};
    dge      = (dtry >= {1'b0, dv});
    res_wide = grad_neg ? (50'(param) + {2'b00, lp}) : (50'(param) - {2'b00, lp});
    res_ovf  = (res_wide[49:31] != {19{1'b0}}) && (res_wide[49:31] != {19{1'b1}});
    res_clip = res_ovf ? (res_wide[49] ? 32'sh80000000 : 32'sh7FFFFFFF)
                       : res_wide[31:0];
  end

  // Store write port: clearing pass, clear command, accumulate write back.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (in_acc && idx_ok && in_ch.data.cmd == CMD_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = AW'(in_ch.data.elem_index);
    end else if (state == ST_ACC) begin
      wr_en   = 1'b1;
      wr_addr = addr;
      wr_data = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (in_acc) rd_data <= mem[AW'(in_ch.data.elem_index)];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      out_full <= 1'b0;
      cnt      <= '0;
    end else begin
      // load a finished result, else drop the flag once the item is taken
      if ((state == ST_FIN || state == ST_PASS) && (!out_full || out_acc)) begin
        out_full <= 1'b1;
      end else if (out_acc) begin
        out_full <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == 32'(ACCUM_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            state <= (idx_ok && in_ch.data.cmd == CMD_UPDATE) ? ST_READ : ST_PASS;
          end
        end
        ST_READ: begin
          cnt   <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd31) state <= ST_ACC;
        end
        ST_ACC: begin
          cnt   <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt == 6'd23) begin
            cnt   <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 6'd47) state <= ST_FIN;
        end
        ST_FIN, ST_PASS: begin
          if (!out_full || out_acc) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        addr     <= AW'(in_ch.data.elem_index);
        param    <= in_ch.data.param_value;
        grad_neg <= in_ch.data.grad_value[VAL_W-1];
        mag      <= in_mag;
        sat      <= 1'b0;
        acc      <= '0;
      end
      ST_READ: begin
        sq_p <= {32'd0, mag};
        lp   <= {32'd0, step_size};
      end
      ST_MUL: begin
        sq_p <= {sq_sum, sq_p[31:1]};
        // lr has 16 bits: advance the rate product in the first half only
        if (cnt < 6'd16) lp <= {lp_sum, lp[15:1]};
      end
      ST_ACC: begin
        acc  <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        sx   <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
        sat  <= acc_sum[ACC_W] || (sq_shift[55:48] != 8'd0);
        srem <= '0;
        root <= '0;
      end
      ST_SQRT: begin
        sx <= {sx[45:0], 2'b00};
        if (srem2 >= strial) begin
          srem <= srem2 - strial;
          root <= {root[22:0], 1'b1};
        end else begin
          srem <= srem2;
          root <= {root[22:0], 1'b0};
        end
        drem <= '0;
      end
      ST_DIV: begin
        if (cnt == 6'd0) begin
          // first step: divisor taken from the finished root plus epsilon
          dv <= {denom, 4'b0000};
          if (dtry >= {1'b0, denom, 4'b0000}) begin
            drem <= 29'(dtry - {1'b0, denom, 4'b0000});
            lp   <= {lp[46:0], 1'b1};
          end else begin
            drem <= dtry[28:0];
            lp   <= {lp[46:0], 1'b0};
          end
        end else begin
          drem <= dge ? 29'(dtry - {1'b0, dv}) : dtry[28:0];
          lp   <= {lp[46:0], dge};
        end
      end
      ST_FIN: begin
        if (!out_full || out_acc) begin
          out_q.new_param <= res_clip;
          out_q.new_accum <= acc;
          out_q.saturated <= sat || res_ovf;
        end
      end
      ST_PASS: begin
        if (!out_full || out_acc) begin
          out_q.new_param <= param;
          out_q.new_accum <= '0;
          out_q.saturated <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Checks.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != ST_IDLE))
    else $error("accepted item did not start work");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_ch.ready && (state == ST_FIN || state == ST_PASS))
      |=> (state == ST_FIN || state == ST_PASS))
    else $error("result dropped while output full");

endmodule
